### rtl/ppwa_pkg.sv
// ----------------------------------------------------------------------------
// ppwa_pkg
// Shared types, constants and helpers of the pair weight accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package ppwa_pkg;

	// Field widths fixed by the interface
	localparam int WORD_W  = 31;
	localparam int WGT_W   = 24;
	localparam int COV_W   = 12;
	localparam int OVL_W   = 11;
	localparam int POP_W   = 5;
	localparam int ACC_W   = 63;
	localparam int ZCNT_W  = 32;
	localparam int PROD1_W = 2 * WGT_W;
	localparam int PROD2_W = PROD1_W + COV_W;
	localparam int FRAC_W  = 16;
	localparam int DIVD_W  = PROD2_W - FRAC_W;
	localparam int STEP_W  = 6;

	// Default parameter values
	localparam int WORDS_PER_PAIR_DEF = 60;
	localparam int BITS_PER_WORD_DEF  = 31;

	// Controller states
	typedef enum logic [1:0] {
		S_RUN,
		S_MUL,
		S_DIV,
		S_ACC
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic load;
		logic div_step;
		logic acc;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pair_end;
		logic term_needed;
		logic term_last_pair;
		logic div_last;
	} sts_t;

	// Mask keeping the low bits of a word that carry realisation bits
	function automatic logic [WORD_W-1:0] word_mask(input int bits);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (i < bits) begin
				m[i] = 1'b1;
			end
		end
		return m;
	endfunction

	// Number of set bits in one word
	function automatic logic [POP_W-1:0] pop_count(input logic [WORD_W-1:0] v);
		logic [POP_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_W; i++) begin
			n = n + POP_W'(v[i]);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### rtl/ppwa_ctrl.sv
// ----------------------------------------------------------------------------
// ppwa_ctrl
// Sequencer of the accumulator: input and output handshakes, and the
// multiply, divide and accumulate steps of one pair term.
// ----------------------------------------------------------------------------
`default_nettype none

module ppwa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire ppwa_pkg::sts_t sts,
	output ppwa_pkg::cmd_t     cmd
);

	ppwa_pkg::state_t state_q;
	ppwa_pkg::state_t state_nxt;
	logic             out_valid_q;
	logic             out_free;
	logic             acc_go;

	// Output register can take a new result this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign acc_go   = !sts.term_last_pair || out_free;

	// Hold the input while a term is worked out, or while an immediate
	// result has nowhere to go
	assign in_stall = (state_q != ppwa_pkg::S_RUN) ||
		(sts.pair_end && !sts.term_needed && !out_free);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ppwa_pkg::S_RUN: begin
				if (cmd.take && sts.term_needed) begin
					state_nxt = ppwa_pkg::S_MUL;
				end
			end
			ppwa_pkg::S_MUL: begin
				state_nxt = ppwa_pkg::S_DIV;
			end
			ppwa_pkg::S_DIV: begin
				if (sts.div_last) begin
					state_nxt = ppwa_pkg::S_ACC;
				end
			end
			ppwa_pkg::S_ACC: begin
				if (acc_go) begin
					state_nxt = ppwa_pkg::S_RUN;
				end
			end
			default: begin
				state_nxt = ppwa_pkg::S_RUN;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.take     = in_valid && !in_stall;
		cmd.load     = (state_q == ppwa_pkg::S_MUL);
		cmd.div_step = (state_q == ppwa_pkg::S_DIV);
		cmd.acc      = (state_q == ppwa_pkg::S_ACC) && acc_go;
		cmd.emit     = (cmd.take && sts.pair_end && !sts.term_needed) ||
			(cmd.acc && sts.term_last_pair);
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppwa_pkg::S_RUN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// A result never overwrites one that is still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result loaded into a full output register");

	// An emitted result is offered in the next cycle
	a_emit_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("emitted result not offered");

	// No transaction is taken while a term is in progress
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ppwa_pkg::S_RUN) |-> !cmd.take)
		else $error("input taken during term evaluation");

	// The divide ends in the accumulate step
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppwa_pkg::S_DIV && sts.div_last) |=> (state_q == ppwa_pkg::S_ACC))
		else $error("divide did not hand over to accumulate");

endmodule

`default_nettype wire

### rtl/ppwa_dp.sv
// ----------------------------------------------------------------------------
// ppwa_dp
// Datapath: overlap count, two-stage weight product, bit-serial divider,
// saturating accumulator, zero-overlap counter and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ppwa_dp #(
	parameter int WORDS_PER_PAIR = ppwa_pkg::WORDS_PER_PAIR_DEF,
	parameter int BITS_PER_WORD  = ppwa_pkg::BITS_PER_WORD_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ppwa_pkg::COV_W-1:0]  cfg_wdata,
	input  wire logic [ppwa_pkg::WORD_W-1:0] word_a,
	input  wire logic [ppwa_pkg::WORD_W-1:0] word_b,
	input  wire logic                        last_word,
	input  wire logic                        selected_a,
	input  wire logic                        selected_b,
	input  wire logic [ppwa_pkg::WGT_W-1:0]  weight_a,
	input  wire logic [ppwa_pkg::WGT_W-1:0]  weight_b,
	input  wire logic                        last_pair,
	input  wire ppwa_pkg::cmd_t              cmd,
	output ppwa_pkg::sts_t                   sts,
	output logic [ppwa_pkg::ACC_W-1:0]       norm_total,
	output logic [ppwa_pkg::ZCNT_W-1:0]      zero_overlap_pairs,
	output logic                             saturated
);

	localparam logic [ppwa_pkg::WORD_W-1:0] WordMask = ppwa_pkg::word_mask(BITS_PER_WORD);
	localparam logic [ppwa_pkg::COV_W-1:0]  CovReset =
		ppwa_pkg::COV_W'((WORDS_PER_PAIR * BITS_PER_WORD) % (2 ** ppwa_pkg::COV_W));
	localparam logic [ppwa_pkg::STEP_W-1:0] DivLast  = ppwa_pkg::STEP_W'(ppwa_pkg::DIVD_W - 1);

	logic [ppwa_pkg::COV_W-1:0]   cov_q;
	logic [ppwa_pkg::OVL_W-1:0]   ovl_q;
	logic [ppwa_pkg::OVL_W:0]     ovl_sum;
	logic [ppwa_pkg::OVL_W-1:0]   ovl_nxt;
	logic                         both_sel;
	logic                         zero_inc;
	logic [ppwa_pkg::PROD1_W-1:0] prod1_q;
	logic [ppwa_pkg::PROD2_W-1:0] prod2;
	logic [ppwa_pkg::OVL_W-1:0]   den_q;
	logic                         lp_q;
	logic [ppwa_pkg::DIVD_W-1:0]  quo_q;
	logic [ppwa_pkg::OVL_W-1:0]   rem_q;
	logic [ppwa_pkg::OVL_W:0]     trial;
	logic                         trial_ge;
	logic [ppwa_pkg::STEP_W-1:0]  step_q;
	logic [ppwa_pkg::ACC_W-1:0]   acc_q;
	logic [ppwa_pkg::ACC_W:0]     acc_sum;
	logic [ppwa_pkg::ACC_W-1:0]   acc_nxt;
	logic                         sat_q;
	logic                         sat_nxt;
	logic [ppwa_pkg::ZCNT_W-1:0]  zcnt_q;
	logic [ppwa_pkg::ZCNT_W-1:0]  zcnt_nxt;
	logic [ppwa_pkg::ACC_W-1:0]   tot_q;
	logic [ppwa_pkg::ZCNT_W-1:0]  zop_q;
	logic                         satf_q;

	// Coverage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_q <= CovReset;
		end else if (cfg_we) begin
			cov_q <= cfg_wdata;
		end
	end

	// Overlap of this word, saturating at the counter maximum
	assign ovl_sum  = {1'b0, ovl_q} +
		(ppwa_pkg::OVL_W + 1)'(ppwa_pkg::pop_count(word_a & word_b & WordMask));
	assign ovl_nxt  = ovl_sum[ppwa_pkg::OVL_W] ? '1 : ovl_sum[ppwa_pkg::OVL_W-1:0];
	assign both_sel = last_word && selected_a && selected_b;
	assign zero_inc = both_sel && (ovl_nxt == '0);

	assign sts.pair_end       = last_word && last_pair;
	assign sts.term_needed    = both_sel && (ovl_nxt != '0);
	assign sts.term_last_pair = lp_q;
	assign sts.div_last       = (step_q == DivLast);

	// Second product stage, drop the fraction below Q.16
	assign prod2 = ppwa_pkg::PROD2_W'(prod1_q) * ppwa_pkg::PROD2_W'(cov_q);

	// One restoring divide step
	assign trial    = {rem_q, quo_q[ppwa_pkg::DIVD_W-1]};
	assign trial_ge = (trial >= {1'b0, den_q});

	// Overlap counter: clear at the end of each pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovl_q <= '0;
		end else if (cmd.take) begin
			ovl_q <= last_word ? '0 : ovl_nxt;
		end
	end

	// Term operands and the divider
	always_ff @(posedge clk) begin
		if (cmd.take && sts.term_needed) begin
			prod1_q <= weight_a * weight_b;
			den_q   <= ovl_nxt;
			lp_q    <= last_pair;
		end
		if (cmd.load) begin
			quo_q  <= prod2[ppwa_pkg::PROD2_W-1:ppwa_pkg::FRAC_W];
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			quo_q  <= {quo_q[ppwa_pkg::DIVD_W-2:0], trial_ge};
			rem_q  <= trial_ge ? ppwa_pkg::OVL_W'(trial - {1'b0, den_q})
				: trial[ppwa_pkg::OVL_W-1:0];
			step_q <= step_q + ppwa_pkg::STEP_W'(1);
		end
	end

	// Next accumulator, flag and zero counter
	assign acc_sum = {1'b0, acc_q} + (ppwa_pkg::ACC_W + 1)'(quo_q);
	always_comb begin
		acc_nxt  = acc_q;
		sat_nxt  = sat_q;
		zcnt_nxt = zcnt_q;
		if (cmd.acc) begin
			if (acc_sum[ppwa_pkg::ACC_W]) begin
				acc_nxt = '1;
				sat_nxt = 1'b1;
			end else begin
				acc_nxt = acc_sum[ppwa_pkg::ACC_W-1:0];
			end
		end
		if (cmd.take && zero_inc && (zcnt_q != '1)) begin
			zcnt_nxt = zcnt_q + ppwa_pkg::ZCNT_W'(1);
		end
	end

	// Totals: clear after emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			sat_q  <= 1'b0;
			zcnt_q <= '0;
		end else if (cmd.emit) begin
			acc_q  <= '0;
			sat_q  <= 1'b0;
			zcnt_q <= '0;
		end else begin
			acc_q  <= acc_nxt;
			sat_q  <= sat_nxt;
			zcnt_q <= zcnt_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			tot_q  <= acc_nxt;
			zop_q  <= zcnt_nxt;
			satf_q <= sat_nxt;
		end
	end

	assign norm_total         = tot_q;
	assign zero_overlap_pairs = zop_q;
	assign saturated          = satf_q;

	// A term is never started without a divisor
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (den_q != '0))
		else $error("term started with zero overlap");

	// The overlap is clear after the last word of a pair
	a_ovl_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && last_word) |=> (ovl_q == '0))
		else $error("overlap not cleared at pair end");

	// Saturation pins the accumulator at its maximum
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc && acc_sum[ppwa_pkg::ACC_W] && !cmd.emit) |=> (acc_q == '1) && sat_q)
		else $error("saturation not held");

endmodule

`default_nettype wire

### rtl/pip_pair_weight_accumulator.sv
// ----------------------------------------------------------------------------
// pip_pair_weight_accumulator
// Sums inverse-probability pair weights over a stream of bitwise weight words.
// ----------------------------------------------------------------------------
// Words go one per cycle unless stalled. A pair ends on the transaction with
// last_word; if both galaxies are selected and their overlap is nonzero the
// term weight_a*weight_b*coverage_total/(overlap*2^16) is worked out by a
// two-stage multiplier and a bit-serial divider that settles one quotient bit
// a cycle, so in_stall stays high after that word for its steps (one multiply
// stage, 44 divide steps, one accumulate). Other words, unselected pairs and
// zero-overlap pairs start no term. On the last word of the final pair the
// total, the zero-overlap count and the saturation flag appear in an output
// register and are cleared; further words are taken while that result waits,
// but the end of a final pair is held (at the input, or in the accumulate
// step when a term is due) until the output register is free. coverage_total
// resets to WORDS_PER_PAIR*BITS_PER_WORD and is written via cfg_we/cfg_wdata;
// the user must do so only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_pair_weight_accumulator #(
	parameter int WORDS_PER_PAIR = ppwa_pkg::WORDS_PER_PAIR_DEF,
	parameter int BITS_PER_WORD  = ppwa_pkg::BITS_PER_WORD_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ppwa_pkg::COV_W-1:0]  cfg_wdata,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [ppwa_pkg::WORD_W-1:0] word_a,
	input  wire logic [ppwa_pkg::WORD_W-1:0] word_b,
	input  wire logic                        last_word,
	input  wire logic                        selected_a,
	input  wire logic                        selected_b,
	input  wire logic [ppwa_pkg::WGT_W-1:0]  weight_a,
	input  wire logic [ppwa_pkg::WGT_W-1:0]  weight_b,
	input  wire logic                        last_pair,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [ppwa_pkg::ACC_W-1:0]       norm_total,
	output logic [ppwa_pkg::ZCNT_W-1:0]      zero_overlap_pairs,
	output logic                             saturated
);

	ppwa_pkg::cmd_t cmd;
	ppwa_pkg::sts_t sts;

	// Sequencer
	ppwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic and storage
	ppwa_dp #(
		.WORDS_PER_PAIR (WORDS_PER_PAIR),
		.BITS_PER_WORD  (BITS_PER_WORD)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.word_a             (word_a),
		.word_b             (word_b),
		.last_word          (last_word),
		.selected_a         (selected_a),
		.selected_b         (selected_b),
		.weight_a           (weight_a),
		.weight_b           (weight_b),
		.last_pair          (last_pair),
		.cmd                (cmd),
		.sts                (sts),
		.norm_total         (norm_total),
		.zero_overlap_pairs (zero_overlap_pairs),
		.saturated          (saturated)
	);

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for pip_pair_weight_accumulator.
// ----------------------------------------------------------------------------
// A directed block covers maximum and zero weights, zero overlap, unselected
// galaxies, last_pair away from a pair end and an empty total. Random phases
// then stream pairs at several coverage_total settings (4095, 1, 0, a random
// value and the reset value). Stalls and gaps are random on both sides. The
// phases also include an overlap count driven into its ceiling and a long
// receiver hold-off. A scoreboard class keeps its own copy of the accumulator
// state, predicts every emitted total and compares the totals field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET   = 700;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int REPORT_LIMIT  = 10;
	localparam int HOLD_CYCLES   = 600;
	localparam int OVERLAP_CEIL  = (1 << ppwa_pkg::OVL_W) - 1;

	localparam logic [ppwa_pkg::COV_W-1:0]  COV_RESET =
		ppwa_pkg::COV_W'(ppwa_pkg::WORDS_PER_PAIR_DEF * ppwa_pkg::BITS_PER_WORD_DEF);
	localparam logic [ppwa_pkg::WORD_W-1:0] WORD_MASK =
		ppwa_pkg::WORD_W'((64'd1 << ppwa_pkg::BITS_PER_WORD_DEF) - 64'd1);
	localparam logic [ppwa_pkg::ACC_W-1:0]  ACC_MAX   = '1;
	localparam logic [ppwa_pkg::WORD_W-1:0] ONES      = '1;
	localparam logic [ppwa_pkg::WGT_W-1:0]  WGT_MAX   = '1;
	localparam logic [ppwa_pkg::WGT_W-1:0]  WGT_ONE   =
		ppwa_pkg::WGT_W'(1 << ppwa_pkg::FRAC_W);

	typedef enum int {
		FILL_RANDOM,
		FILL_SPARSE,
		FILL_DISJOINT,
		FILL_DENSE
	} fill_t;

	typedef struct {
		logic [ppwa_pkg::WORD_W-1:0] word_a;
		logic [ppwa_pkg::WORD_W-1:0] word_b;
		logic                        last_word;
		logic                        selected_a;
		logic                        selected_b;
		logic [ppwa_pkg::WGT_W-1:0]  weight_a;
		logic [ppwa_pkg::WGT_W-1:0]  weight_b;
		logic                        last_pair;
	} pair_word_t;

	typedef struct {
		logic [ppwa_pkg::ACC_W-1:0]  total;
		logic [ppwa_pkg::ZCNT_W-1:0] zero_pairs;
		logic                        clipped;
	} pair_total_t;

	// Running pair sum: own copy of the block state and the totals still due
	class pair_sum_tracker;
		logic [ppwa_pkg::COV_W-1:0]  coverage;
		int                          overlap;
		logic [ppwa_pkg::ACC_W-1:0]  acc;
		logic [ppwa_pkg::ZCNT_W-1:0] zero_pairs;
		logic                        clipped;
		pair_total_t                 totals_due[$];
		int                          emitted;
		int                          errors;

		function new();
			coverage   = COV_RESET;
			overlap    = 0;
			acc        = '0;
			zero_pairs = '0;
			clipped    = 1'b0;
			emitted    = 0;
			errors     = 0;
		endfunction

		// Fold one accepted word into the pair and close the pair on last_word
		function void note_word(pair_word_t w);
			logic [63:0]                 num;
			logic [63:0]                 den;
			logic [63:0]                 term;
			logic [63:0]                 sum;
			logic [ppwa_pkg::WORD_W-1:0] shared;
			pair_total_t                 t;
			shared = w.word_a & w.word_b & WORD_MASK;
			overlap += $countones(shared);
			if (overlap > OVERLAP_CEIL) begin
				overlap = OVERLAP_CEIL;
			end
			if (!w.last_word) begin
				return;
			end
			if (w.selected_a && w.selected_b) begin
				if (overlap == 0) begin
					if (zero_pairs != '1) begin
						zero_pairs++;
					end
				end else begin
					num  = 64'(w.weight_a) * 64'(w.weight_b) * 64'(coverage);
					den  = 64'(overlap) << ppwa_pkg::FRAC_W;
					term = num / den;
					sum  = 64'(acc) + term;
					if (sum > 64'(ACC_MAX)) begin
						sum     = 64'(ACC_MAX);
						clipped = 1'b1;
					end
					acc = sum[ppwa_pkg::ACC_W-1:0];
				end
			end
			overlap = 0;
			if (!w.last_pair) begin
				return;
			end
			t.total      = acc;
			t.zero_pairs = zero_pairs;
			t.clipped    = clipped;
			totals_due.push_back(t);
			emitted++;
			acc        = '0;
			zero_pairs = '0;
			clipped    = 1'b0;
		endfunction

		function void flag(string what, logic [63:0] want, logic [63:0] got);
			errors++;
			if (errors <= REPORT_LIMIT) begin
				$display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
			end
		endfunction

		// Compare an emitted total with the oldest one due
		function void check_total(logic [ppwa_pkg::ACC_W-1:0] total,
				logic [ppwa_pkg::ZCNT_W-1:0] zp, logic sat);
			pair_total_t t;
			if (totals_due.size() == 0) begin
				flag("norm_total of a total nobody asked for", '0, 64'(total));
				return;
			end
			t = totals_due.pop_front();
			if (total !== t.total) begin
				flag("norm_total", 64'(t.total), 64'(total));
			end
			if (zp !== t.zero_pairs) begin
				flag("zero_overlap_pairs", 64'(t.zero_pairs), 64'(zp));
			end
			if (sat !== t.clipped) begin
				flag("saturated", 64'(t.clipped), 64'(sat));
			end
		endfunction
	endclass

	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        cfg_we     = 1'b0;
	logic [ppwa_pkg::COV_W-1:0]  cfg_wdata  = '0;
	logic                        in_valid   = 1'b0;
	logic                        in_stall;
	logic [ppwa_pkg::WORD_W-1:0] word_a     = '0;
	logic [ppwa_pkg::WORD_W-1:0] word_b     = '0;
	logic                        last_word  = 1'b0;
	logic                        selected_a = 1'b0;
	logic                        selected_b = 1'b0;
	logic [ppwa_pkg::WGT_W-1:0]  weight_a   = '0;
	logic [ppwa_pkg::WGT_W-1:0]  weight_b   = '0;
	logic                        last_pair  = 1'b0;
	logic                        out_valid;
	logic                        out_stall  = 1'b0;
	logic [ppwa_pkg::ACC_W-1:0]  norm_total;
	logic [ppwa_pkg::ZCNT_W-1:0] zero_overlap_pairs;
	logic                        saturated;

	pair_sum_tracker track = new();
	int              items_sent  = 0;
	int              hold_off    = 0;
	int              stall_run   = 0;
	int              stall_pick  = 0;
	logic            stall_level = 1'b0;
	int              cycle_count = 0;

	pip_pair_weight_accumulator DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.word_a             (word_a),
		.word_b             (word_b),
		.last_word          (last_word),
		.selected_a         (selected_a),
		.selected_b         (selected_b),
		.weight_a           (weight_a),
		.weight_b           (weight_b),
		.last_pair          (last_pair),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.norm_total         (norm_total),
		.zero_overlap_pairs (zero_overlap_pairs),
		.saturated          (saturated)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: a long hold-off when asked, otherwise random stall runs
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			out_stall <= 1'b1;
		end else begin
			if (stall_run == 0) begin
				stall_pick = $urandom_range(0, 99);
				if (stall_pick < 50) begin
					stall_level = 1'b0;
					stall_run   = $urandom_range(1, 8);
				end else if (stall_pick < 85) begin
					stall_level = 1'b1;
					stall_run   = $urandom_range(1, 3);
				end else if (stall_pick < 95) begin
					stall_level = 1'b0;
					stall_run   = $urandom_range(20, 60);
				end else begin
					stall_level = 1'b1;
					stall_run   = $urandom_range(20, 60);
				end
			end
			stall_run--;
			out_stall <= stall_level;
		end
	end

	// Check every total taken from the block
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			track.check_total(norm_total, zero_overlap_pairs, saturated);
		end
	end

	// Bound the run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("pip_pair_weight_accumulator verification failed");
		$finish;
	end

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [ppwa_pkg::WGT_W-1:0] pick_weight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return '0;
		end else if (r < 20) begin
			return WGT_MAX;
		end else if (r < 40) begin
			return ppwa_pkg::WGT_W'($urandom_range(0, 65535));
		end
		return ppwa_pkg::WGT_W'($urandom());
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return $urandom_range(1, 3);
		end else if (r < 85) begin
			return $urandom_range(4, 12);
		end else if (r < 96) begin
			return $urandom_range(1, 2);
		end else if (r < 99) begin
			return ppwa_pkg::WORDS_PER_PAIR_DEF;
		end
		return $urandom_range(61, 70);
	endfunction

	function automatic fill_t pick_fill();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return FILL_RANDOM;
		end else if (r < 75) begin
			return FILL_SPARSE;
		end else if (r < 90) begin
			return FILL_DISJOINT;
		end
		return FILL_DENSE;
	endfunction

	// Offer one word after a random gap and hold it until accepted
	task automatic send_word(input pair_word_t w);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		word_a     <= w.word_a;
		word_b     <= w.word_b;
		last_word  <= w.last_word;
		selected_a <= w.selected_a;
		selected_b <= w.selected_b;
		weight_a   <= w.weight_a;
		weight_b   <= w.weight_b;
		last_pair  <= w.last_pair;
		do @(posedge clk); while (in_stall);
		track.note_word(w);
		items_sent++;
	endtask

	task automatic send_fields(input logic [ppwa_pkg::WORD_W-1:0] wa,
			input logic [ppwa_pkg::WORD_W-1:0] wb,
			input logic lw, input logic sa, input logic sb,
			input logic [ppwa_pkg::WGT_W-1:0] ga, input logic [ppwa_pkg::WGT_W-1:0] gb,
			input logic lp);
		pair_word_t w;
		w.word_a     = wa;
		w.word_b     = wb;
		w.last_word  = lw;
		w.selected_a = sa;
		w.selected_b = sb;
		w.weight_a   = ga;
		w.weight_b   = gb;
		w.last_pair  = lp;
		send_word(w);
	endtask

	// Stream one pair; fields read only on the last word are noise elsewhere
	task automatic send_pair(input int n_words, input logic final_pair, input fill_t fill);
		pair_word_t                 w;
		logic                       sa;
		logic                       sb;
		logic [ppwa_pkg::WGT_W-1:0] ga;
		logic [ppwa_pkg::WGT_W-1:0] gb;
		logic                       is_last;
		if (fill == FILL_DENSE || $urandom_range(0, 99) < 75) begin
			sa = 1'b1;
			sb = 1'b1;
		end else begin
			sa = 1'($urandom_range(0, 1));
			sb = 1'($urandom_range(0, 1));
		end
		ga = pick_weight();
		gb = pick_weight();
		for (int i = 0; i < n_words; i++) begin
			is_last = (i == n_words - 1);
			case (fill)
				FILL_SPARSE: begin
					w.word_a = ppwa_pkg::WORD_W'($urandom());
					w.word_b = ppwa_pkg::WORD_W'($urandom() & $urandom() & $urandom());
				end
				FILL_DISJOINT: begin
					w.word_a = ppwa_pkg::WORD_W'($urandom());
					w.word_b = ~w.word_a;
				end
				FILL_DENSE: begin
					w.word_a = ONES;
					w.word_b = ONES;
				end
				default: begin
					w.word_a = ppwa_pkg::WORD_W'($urandom());
					w.word_b = ppwa_pkg::WORD_W'($urandom());
				end
			endcase
			w.last_word  = is_last;
			w.selected_a = is_last ? sa : 1'($urandom_range(0, 1));
			w.selected_b = is_last ? sb : 1'($urandom_range(0, 1));
			w.weight_a   = is_last ? ga : pick_weight();
			w.weight_b   = is_last ? gb : pick_weight();
			w.last_pair  = is_last ? final_pair : ($urandom_range(0, 19) == 0);
			send_word(w);
		end
	endtask

	// Drop valid, wait for every total due, then let the pipeline drain
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (track.totals_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_coverage(input logic [ppwa_pkg::COV_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		track.coverage = value;
	endtask

	// Random pairs up to an item budget, closed by a final pair
	task automatic run_phase(input int item_budget);
		int start;
		start = items_sent;
		while (items_sent - start < item_budget) begin
			send_pair(pick_len(), ($urandom_range(0, 2) == 0), pick_fill());
		end
		send_pair($urandom_range(1, 3), 1'b1, pick_fill());
		settle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes and corner cases at the reset coverage
		send_fields(ONES, ONES, 1'b1, 1'b1, 1'b1, WGT_MAX, WGT_MAX, 1'b0);
		send_fields(ONES, '0, 1'b1, 1'b1, 1'b1, WGT_MAX, WGT_ONE, 1'b0);
		send_fields(ONES, ONES, 1'b1, 1'b0, 1'b1, WGT_MAX, WGT_MAX, 1'b0);
		send_fields(ONES, ONES, 1'b1, 1'b1, 1'b0, WGT_MAX, WGT_MAX, 1'b0);
		send_fields(ONES, ONES, 1'b1, 1'b0, 1'b0, WGT_MAX, WGT_MAX, 1'b0);
		send_fields(31'h5555_5555, 31'h5555_5555, 1'b0, 1'b1, 1'b1, '0, '0, 1'b1);
		send_fields(31'h2AAA_AAAA, 31'h2AAA_AAAA, 1'b1, 1'b1, 1'b1, '0, WGT_MAX, 1'b0);
		send_fields(31'h4000_0001, 31'h4000_0001, 1'b1, 1'b1, 1'b1, WGT_ONE, WGT_ONE, 1'b1);
		send_fields('0, '0, 1'b1, 1'b0, 1'b0, '0, '0, 1'b1);
		send_fields(31'h0000_0001, 31'h0000_0001, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0);
		send_fields(31'h4000_0000, 31'h4000_0000, 1'b0, 1'b1, 1'b0, WGT_MAX, '0, 1'b0);
		send_fields('0, ONES, 1'b1, 1'b1, 1'b1, WGT_MAX, 24'h000001, 1'b1);
		send_fields('0, '0, 1'b1, 1'b1, 1'b1, WGT_MAX, WGT_MAX, 1'b0);
		send_fields(ONES, ONES, 1'b1, 1'b1, 1'b1, 24'h000001, 24'h000001, 1'b1);
		settle();

		// Largest coverage, with one pair long enough to clip the overlap count
		write_coverage('1);
		send_pair(70, 1'b0, FILL_DENSE);
		send_pair(1, 1'b1, FILL_SPARSE);
		run_phase(130);

		// Smallest nonzero coverage; hold the receiver off while finals pile up
		write_coverage(ppwa_pkg::COV_W'(1));
		hold_off = HOLD_CYCLES;
		repeat (4) send_pair(1, 1'b1, FILL_RANDOM);
		run_phase(130);

		// Zero coverage: every term vanishes
		write_coverage('0);
		run_phase(110);

		write_coverage(ppwa_pkg::COV_W'($urandom_range(2, 4094)));
		run_phase(130);

		// Back to the reset value until enough items have gone through
		write_coverage(COV_RESET);
		while (items_sent < ITEM_TARGET) begin
			run_phase(60);
		end

		settle();
		if (track.errors == 0 && track.totals_due.size() == 0) begin
			$display("pip_pair_weight_accumulator verification clean");
		end else begin
			$display("pip_pair_weight_accumulator verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
